// ----- rtl/core/sdbg_pkg.sv -----
// Shared types, widths and constants of the step/direction burst generator.
package sdbg_pkg;

  localparam int TICK_W       = 20;
  localparam int PULSE_W      = 10;
  localparam int STEPS_W      = 13;
  localparam int FUNC_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 20;
  localparam int DEF_MAX_STEPS = 4095;

  localparam logic [TICK_W-1:0]  RST_TICK_US  = TICK_W'(20000);
  localparam logic [PULSE_W-1:0] RST_PULSE_US = PULSE_W'(10);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_MOVE  = 2'd1,
    FUNC_ABORT = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BUSY    = 2'd1,
    ST_BLOCKED = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_US      = 3'd0,
    CFG_PULSE_US     = 3'd1,
    CFG_DIR_INVERT   = 3'd2,
    CFG_STOP_ACT_HI  = 3'd3,
    CFG_LOW_PRESENT  = 3'd4,
    CFG_HIGH_PRESENT = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DIV  = 1'b1
  } state_t;

  typedef struct packed {
    logic take_imm;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_needed;
    logic div_done;
  } dp_stat_t;

endpackage

// ----- rtl/core/sdbg_if.sv -----
// Handshake channel interfaces for input items and result items.
interface sdbg_in_if
  import sdbg_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [STEPS_W-1:0]  move_steps;
  logic                       low_stop_level;
  logic                       high_stop_level;

  modport source (output valid, func, move_steps, low_stop_level, high_stop_level,
                  input ready);
  modport sink   (input valid, func, move_steps, low_stop_level, high_stop_level,
                  output ready);
endinterface

interface sdbg_out_if
  import sdbg_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [STEPS_W-1:0]  steps_taken;
  logic                       pulse_pin;
  logic                       dir_pin;
  logic                       burst_active;

  modport source (output valid, status, steps_taken, pulse_pin, dir_pin, burst_active,
                  input ready);
  modport sink   (input valid, status, steps_taken, pulse_pin, dir_pin, burst_active,
                  output ready);
endinterface

// ----- rtl/core/step_dir_burst_generator.sv -----
// Step/direction burst generator top level.
// Each input item is a one-microsecond tick, a move command or an abort, and
// each yields exactly one result item from a registered output stage, so the
// next item is taken in the same cycle that the previous result is collected.
// Ticks, aborts, zero-step moves and refused moves (busy or blocked) have
// their result registered in the next cycle. A move that starts a burst
// first finds the period tick_us / count with a restoring divider that
// produces one quotient bit per cycle over the 20-bit tick length.
// Configuration writes apply on the cycle after the write enable and should
// only be made while no item is in flight.
module step_dir_burst_generator
  import sdbg_pkg::*;
#(
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sdbg_in_if.sink               in_chan,
  sdbg_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sdbg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sdbg_dp #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .func             (in_chan.func),
    .move_steps       (in_chan.move_steps),
    .low_stop_level   (in_chan.low_stop_level),
    .high_stop_level  (in_chan.high_stop_level),
    .cmd              (cmd),
    .stat             (stat),
    .res_status       (out_chan.status),
    .res_steps_taken  (out_chan.steps_taken),
    .res_pulse_pin    (out_chan.pulse_pin),
    .res_dir_pin      (out_chan.dir_pin),
    .res_burst_active (out_chan.burst_active)
  );

endmodule

// ----- rtl/core/sdbg_div.sv -----
// Restoring divider that yields one quotient bit per clock cycle.
module sdbg_div
  import sdbg_pkg::*;
#(
  parameter int DIV_W = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TICK_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [TICK_W-1:0] quotient
);

  localparam int CNT_W = $clog2(TICK_W + 1);

  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [TICK_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0]  dvs_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, quo_r[TICK_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(TICK_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_W'(trial - {1'b0, dvs_r}) : DIV_W'(trial);
      quo_nxt = {quo_r[TICK_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/core/sdbg_dp.sv -----
// Datapath: configuration registers, burst state, period divider and result register.
module sdbg_dp
  import sdbg_pkg::*;
#(
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_idx,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [FUNC_W-1:0]         func,
  input  logic signed [STEPS_W-1:0] move_steps,
  input  logic                      low_stop_level,
  input  logic                      high_stop_level,
  input  ctrl_cmd_t                 cmd,
  output dp_stat_t                  stat,
  output logic [STATUS_W-1:0]       res_status,
  output logic signed [STEPS_W-1:0] res_steps_taken,
  output logic                      res_pulse_pin,
  output logic                      res_dir_pin,
  output logic                      res_burst_active
);

  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int MW = (CW > STEPS_W) ? CW : STEPS_W;
  localparam logic [MW-1:0] MAX_MW = MW'(MAX_STEPS);

  logic [TICK_W-1:0]  tick_us_r;
  logic [PULSE_W-1:0] pulse_us_r;
  logic               dir_invert_r;
  logic               stop_act_hi_r;
  logic               low_present_r;
  logic               high_present_r;

  logic [CW-1:0]      pulses_left_r, pulses_left_nxt;
  logic [TICK_W-1:0]  phase_r, phase_nxt;
  logic [TICK_W-1:0]  period_r, period_nxt;
  logic               pulse_r, pulse_nxt;
  logic               dir_r, dir_nxt;

  logic [CW-1:0]      count_r;
  logic               neg_r;
  logic [STEPS_W-1:0] taken_r;

  logic [STATUS_W-1:0]       res_status_r;
  logic signed [STEPS_W-1:0] res_taken_r;
  logic                      res_pulse_r;
  logic                      res_dir_r;
  logic                      res_active_r;

  logic               neg;
  logic [STEPS_W-1:0] mag;
  logic [MW-1:0]      mag_mw;
  logic [MW-1:0]      count_mw;
  logic               engaged;
  logic               busy;
  logic [TICK_W-1:0]  phase_inc;
  logic [CW-1:0]      pulses_dec;
  logic [TICK_W-1:0]  min_period;
  logic [TICK_W-1:0]  quotient;
  logic               div_done;
  logic [STATUS_W-1:0] status_nxt;
  logic [STEPS_W-1:0]  taken_nxt;

  assign neg      = move_steps[STEPS_W-1];
  assign mag      = neg ? STEPS_W'(~move_steps + 1'b1) : STEPS_W'(move_steps);
  assign mag_mw   = MW'(mag);
  assign count_mw = (mag_mw > MAX_MW) ? MAX_MW : mag_mw;
  assign engaged  = neg ? (low_present_r && (low_stop_level == stop_act_hi_r))
                        : (high_present_r && (high_stop_level == stop_act_hi_r));
  assign busy     = pulses_left_r != '0;

  assign stat.start_needed = (func == FUNC_MOVE) && (mag != '0) && !busy && !engaged;
  assign stat.div_done     = div_done;

  sdbg_div #(
    .DIV_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (tick_us_r),
    .divisor  (CW'(count_mw)),
    .done     (div_done),
    .quotient (quotient)
  );

  assign phase_inc  = phase_r + 1'b1;
  assign pulses_dec = pulses_left_r - 1'b1;
  assign min_period = TICK_W'({pulse_us_r, 1'b0});

  always_comb begin
    pulses_left_nxt = pulses_left_r;
    phase_nxt       = phase_r;
    period_nxt      = period_r;
    pulse_nxt       = pulse_r;
    dir_nxt         = dir_r;
    status_nxt      = ST_DONE;
    taken_nxt       = '0;
    if (cmd.commit) begin
      dir_nxt         = neg_r ^ dir_invert_r;
      period_nxt      = (quotient > min_period) ? quotient : min_period;
      pulses_left_nxt = count_r;
      phase_nxt       = '0;
      pulse_nxt       = pulse_us_r != '0;
      taken_nxt       = taken_r;
    end else if (cmd.take_imm) begin
      case (func)
        FUNC_TICK: begin
          if (busy) begin
            if (phase_inc >= period_r) begin
              pulses_left_nxt = pulses_dec;
              phase_nxt       = '0;
              pulse_nxt       = (pulses_dec != '0) && (pulse_us_r != '0);
            end else begin
              phase_nxt = phase_inc;
              if (phase_inc >= TICK_W'(pulse_us_r)) begin
                pulse_nxt = 1'b0;
              end
            end
          end
        end
        FUNC_MOVE: begin
          if (mag == '0) begin
            status_nxt = ST_DONE;
          end else if (busy) begin
            status_nxt = ST_BUSY;
          end else begin
            status_nxt = ST_BLOCKED;
          end
        end
        FUNC_ABORT: begin
          pulses_left_nxt = '0;
          phase_nxt       = '0;
          pulse_nxt       = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_us_r      <= RST_TICK_US;
      pulse_us_r     <= RST_PULSE_US;
      dir_invert_r   <= 1'b0;
      stop_act_hi_r  <= 1'b1;
      low_present_r  <= 1'b0;
      high_present_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TICK_US:      tick_us_r      <= cfg_wdata[TICK_W-1:0];
        CFG_PULSE_US:     pulse_us_r     <= cfg_wdata[PULSE_W-1:0];
        CFG_DIR_INVERT:   dir_invert_r   <= cfg_wdata[0];
        CFG_STOP_ACT_HI:  stop_act_hi_r  <= cfg_wdata[0];
        CFG_LOW_PRESENT:  low_present_r  <= cfg_wdata[0];
        CFG_HIGH_PRESENT: high_present_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulses_left_r <= '0;
      phase_r       <= '0;
      period_r      <= '0;
      pulse_r       <= 1'b0;
      dir_r         <= 1'b0;
    end else begin
      pulses_left_r <= pulses_left_nxt;
      phase_r       <= phase_nxt;
      period_r      <= period_nxt;
      pulse_r       <= pulse_nxt;
      dir_r         <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      count_r <= CW'(count_mw);
      neg_r   <= neg;
      taken_r <= neg ? STEPS_W'(~STEPS_W'(count_mw) + 1'b1) : STEPS_W'(count_mw);
    end
    if (cmd.take_imm || cmd.commit) begin
      res_status_r <= status_nxt;
      res_taken_r  <= taken_nxt;
      res_pulse_r  <= pulse_nxt;
      res_dir_r    <= dir_nxt;
      res_active_r <= pulses_left_nxt != '0;
    end
  end

  assign res_status       = res_status_r;
  assign res_steps_taken  = res_taken_r;
  assign res_pulse_pin    = res_pulse_r;
  assign res_dir_pin      = res_dir_r;
  assign res_burst_active = res_active_r;

endmodule

// ----- rtl/core/sdbg_ctrl.sv -----
// Controller state machine that sequences item intake, the period divide and the result.
module sdbg_ctrl
  import sdbg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    accept        = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        accept   = in_valid && in_ready;
        if (accept) begin
          if (stat.start_needed) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            cmd.take_imm  = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
